// ===== hw/rtl/lmt_pkg.sv =====
// shared types, field widths and codes of the link member table
package lmt_pkg;

  localparam int unsigned SLOTS_DEF   = 8;
  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned LIST_CNT_W  = $clog2(MAX_RESULTS + 1);

  localparam int unsigned OP_W     = 3;
  localparam int unsigned LINK_W   = 16;
  localparam int unsigned MEMBER_W = 8;
  localparam int unsigned RSSI_W   = 8;
  localparam int unsigned ADDR_W   = 48;
  localparam int unsigned PAIR_W   = 16;
  localparam int unsigned COUNT_W  = 4;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = CFG_ADDR_W - 2;

  localparam logic [CFG_IDX_W-1:0] REG_RSSI_UNKNOWN = '0;

  localparam logic [MEMBER_W-1:0]      MEMBER_NONE      = 8'h00;
  localparam logic [MEMBER_W-1:0]      MEMBER_MAX       = 8'd254;
  localparam logic [MEMBER_W-1:0]      MEMBER_BCAST     = 8'hFF;
  localparam logic signed [RSSI_W-1:0] RSSI_UNKNOWN_RST = -8'sd128;

  typedef enum logic [OP_W-1:0] {
    OP_CONNECT,
    OP_DISCONNECT,
    OP_PAIR_DONE,
    OP_BIND,
    OP_RSSI,
    OP_FIND_LINK,
    OP_FIND_MEMBER,
    OP_LIST
  } op_t;

  typedef struct packed {
    logic [LINK_W-1:0]        link;
    logic [MEMBER_W-1:0]      member;
    logic signed [RSSI_W-1:0] rssi;
    logic [ADDR_W-1:0]        addr;
  } slot_word_t;

  typedef struct packed {
    logic link_hit;
    logic member_hit;
  } cmp_res_t;

endpackage

// ===== hw/rtl/lmt_if.sv =====
// request and result channel interfaces of the link member table
interface lmt_in_if import lmt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic [LINK_W-1:0]        link_id;
  logic [MEMBER_W-1:0]      member_in;
  logic signed [RSSI_W-1:0] rssi_in;
  logic                     status_ok;
  logic [ADDR_W-1:0]        peer_addr;
  logic                     addr_present;

  modport source (
    output valid, operation, link_id, member_in, rssi_in, status_ok, peer_addr, addr_present,
    input  ready
  );
  modport sink (
    input  valid, operation, link_id, member_in, rssi_in, status_ok, peer_addr, addr_present,
    output ready
  );
endinterface

interface lmt_out_if import lmt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     found;
  logic [LINK_W-1:0]        link_out;
  logic [MEMBER_W-1:0]      member_out;
  logic signed [RSSI_W-1:0] rssi_out;
  logic [ADDR_W-1:0]        addr_out;
  logic                     drop_request;
  logic [PAIR_W-1:0]        pair_handle;
  logic [COUNT_W-1:0]       active_count;
  logic                     last;

  modport source (
    output valid, found, link_out, member_out, rssi_out, addr_out, drop_request,
           pair_handle, active_count, last,
    input  ready
  );
  modport sink (
    input  valid, found, link_out, member_out, rssi_out, addr_out, drop_request,
           pair_handle, active_count, last,
    output ready
  );
endinterface

// ===== hw/rtl/lmt_cfg_regs.sv =====
// apb register holding the strength written into fresh slots
module lmt_cfg_regs import lmt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_W-1:0]    paddr,
  input  logic [CFG_DATA_W-1:0]    pwdata,
  output logic [CFG_DATA_W-1:0]    prdata,
  output logic                     pready,
  output logic signed [RSSI_W-1:0] rssi_unknown
);

  logic signed [RSSI_W-1:0] rssi_unknown_r;
  logic [CFG_IDX_W-1:0]     reg_idx;
  logic                     wr_hit;

  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_hit  = psel && penable && pwrite && (reg_idx == REG_RSSI_UNKNOWN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rssi_unknown_r <= RSSI_UNKNOWN_RST;
    end else if (wr_hit) begin
      rssi_unknown_r <= pwdata[RSSI_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_RSSI_UNKNOWN) begin
      prdata = CFG_DATA_W'(rssi_unknown_r);
    end
  end

  assign rssi_unknown = rssi_unknown_r;

endmodule

// ===== hw/rtl/lmt_slot_ram.sv =====
// slot contents store, one write and one registered read port
module lmt_slot_ram import lmt_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF,
  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [IdxW-1:0] wr_addr,
  input  slot_word_t      wr_data,
  input  logic            rd_en,
  input  logic [IdxW-1:0] rd_addr,
  output slot_word_t      rd_data
);

  slot_word_t mem [SLOTS];
  slot_word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/lmt_cmp_unit.sv =====
// shared compare unit: checks one slot word against the request keys
module lmt_cmp_unit import lmt_pkg::*; (
  input  slot_word_t          word,
  input  logic                slot_act,
  input  logic [LINK_W-1:0]   key_link,
  input  logic [MEMBER_W-1:0] key_member,
  output cmp_res_t            res
);

  logic member_ok;

  // member zero and broadcast never match
  assign member_ok      = (key_member != MEMBER_NONE) && (key_member != MEMBER_BCAST);
  assign res.link_hit   = slot_act && (word.link == key_link);
  assign res.member_hit = slot_act && member_ok && (word.member == key_member);

endmodule

// ===== hw/rtl/link_member_table.sv =====
// link member table: top level with the slot scan sequencer
//
// One request on in_ch is taken when the block is idle (in_ch.ready high).
// The sequencer then walks the slot store one slot a cycle through a shared
// compare unit, over the single read port of the slot store; a bind with a
// usable member walks the store twice.
// List gives one result per active slot, at most eight; with no active slot it
// gives a single result with found low. Every other request gives one result.
// Results sit in an output register on out_ch; a stalled receiver holds the
// sequencer once it has a result to give, and the next request is taken once
// the last result of the current one is in the output register, even if that
// one waits.
// Reset (rst_n low, synchronous) marks all slots inactive, clears the count
// and the pair handle, and sets the fresh slot strength register to -128.
// The apb port at cfg_ holds that register at byte address 0; the user must
// write it only while no request is in progress (not enforced by the block).
module link_member_table import lmt_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lmt_in_if.sink                in_ch,
  lmt_out_if.source             out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = $clog2(SLOTS + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);
  localparam logic [CntW-1:0] SlotsCnt = CntW'(SLOTS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CLEAR,
    ST_FINISH,
    ST_LIST_SKIP,
    ST_LIST_EMIT
  } state_t;

  // request capture
  state_t                   state_r, state_nxt;
  op_t                      op_r, op_nxt;
  logic [LINK_W-1:0]        link_r, link_nxt;
  logic [MEMBER_W-1:0]      member_r, member_nxt;
  logic signed [RSSI_W-1:0] rssi_r, rssi_nxt;
  logic                     ok_r, ok_nxt;
  logic [ADDR_W-1:0]        addr_r, addr_nxt;
  logic                     has_addr_r, has_addr_nxt;

  // table state
  logic [SLOTS-1:0]         active_r, active_nxt;
  logic [CntW-1:0]          used_r, used_nxt;
  logic [PAIR_W-1:0]        pair_r, pair_nxt;

  // walk control
  logic [CntW-1:0]          issue_r, issue_nxt;
  logic                     chk_vld_r, chk_vld_nxt;
  logic [IdxW-1:0]          chk_idx_r, chk_idx_nxt;
  logic [LIST_CNT_W-1:0]    list_n_r, list_n_nxt;

  // scan findings
  logic                     hit_vld_r, hit_vld_nxt;
  logic [IdxW-1:0]          hit_idx_r, hit_idx_nxt;
  slot_word_t               hit_word_r, hit_word_nxt;
  logic                     free_vld_r, free_vld_nxt;
  logic [IdxW-1:0]          free_idx_r, free_idx_nxt;
  logic                     first_vld_r, first_vld_nxt;
  logic [IdxW-1:0]          first_idx_r, first_idx_nxt;
  logic [LINK_W-1:0]        first_link_r, first_link_nxt;
  logic                     other_vld_r, other_vld_nxt;
  logic [LINK_W-1:0]        other_link_r, other_link_nxt;

  // output register
  logic                     out_vld_r, out_vld_nxt;
  logic                     out_found_r, out_found_nxt;
  logic [LINK_W-1:0]        out_link_r, out_link_nxt;
  logic [MEMBER_W-1:0]      out_member_r, out_member_nxt;
  logic signed [RSSI_W-1:0] out_rssi_r, out_rssi_nxt;
  logic [ADDR_W-1:0]        out_addr_r, out_addr_nxt;
  logic                     out_drop_r, out_drop_nxt;
  logic [PAIR_W-1:0]        out_pair_r, out_pair_nxt;
  logic [COUNT_W-1:0]       out_count_r, out_count_nxt;
  logic                     out_last_r, out_last_nxt;

  // store ports and compare unit
  logic                     rd_en, wr_en;
  logic [IdxW-1:0]          wr_addr;
  slot_word_t               wr_data, rd_data, clr_word;
  cmp_res_t                 cmp;
  logic signed [RSSI_W-1:0] rssi_unknown;

  // finish step
  logic                     out_free, member_bad, s_ok, chk_last, key_hit, chk_act;
  logic [IdxW-1:0]          s_idx, walk_idx;
  slot_word_t               base_word, new_word;
  logic                     fin_found, fin_use_word, fin_drop, fin_wr, fin_alloc, fin_release;
  logic [LINK_W-1:0]        fin_link;
  logic [ADDR_W-1:0]        fin_addr;
  logic [CntW-1:0]          fin_used;
  logic [PAIR_W-1:0]        fin_pair, alloc_pair;
  logic [SLOTS-1:0]         above_mask;
  logic                     list_last;

  lmt_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (cfg_psel),
    .penable      (cfg_penable),
    .pwrite       (cfg_pwrite),
    .paddr        (cfg_paddr),
    .pwdata       (cfg_pwdata),
    .prdata       (cfg_prdata),
    .pready       (cfg_pready),
    .rssi_unknown (rssi_unknown)
  );

  lmt_slot_ram #(.SLOTS(SLOTS)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (walk_idx),
    .rd_data (rd_data)
  );

  lmt_cmp_unit u_cmp (
    .word       (rd_data),
    .slot_act   (chk_act),
    .key_link   (link_r),
    .key_member (member_r),
    .res        (cmp)
  );

  assign walk_idx   = issue_r[IdxW-1:0];
  assign chk_act    = active_r[chk_idx_r];
  assign chk_last   = chk_vld_r && (chk_idx_r == LastIdx);
  assign key_hit    = (op_r == OP_FIND_MEMBER) ? cmp.member_hit : cmp.link_hit;
  assign out_free   = !out_vld_r || out_ch.ready;
  assign member_bad = (member_r == MEMBER_NONE) || (member_r > MEMBER_MAX);
  assign s_ok       = hit_vld_r || free_vld_r;
  assign s_idx      = hit_vld_r ? hit_idx_r : free_idx_r;

  always_comb begin
    clr_word        = rd_data;
    clr_word.member = MEMBER_NONE;
  end

  // slots above the current list position, for the last flag
  always_comb begin
    for (int j = 0; j < SLOTS; j++) begin
      above_mask[j] = (j > int'(walk_idx));
    end
    list_last = (list_n_r == LIST_CNT_W'(MAX_RESULTS - 1)) || !(|(active_r & above_mask));
  end

  // result and state changes of a finished scan
  always_comb begin
    if (hit_vld_r) begin
      base_word = hit_word_r;
    end else begin
      base_word = '{link: link_r, member: MEMBER_NONE, rssi: rssi_unknown, addr: '0};
    end
    new_word = base_word;
    if (op_r == OP_CONNECT && has_addr_r) begin
      new_word.addr = addr_r;
    end
    if (op_r == OP_BIND && !member_bad) begin
      new_word.member = member_r;
    end
    if (op_r == OP_RSSI && ok_r) begin
      new_word.rssi = rssi_r;
    end

    // a fresh slot below the lowest active one gives the pair handle, its link plus one
    if (hit_vld_r || !free_vld_r) begin
      alloc_pair = PAIR_W'(first_link_r + 1'b1);
    end else if (!first_vld_r || (free_idx_r < first_idx_r)) begin
      alloc_pair = PAIR_W'(link_r + 1'b1);
    end else begin
      alloc_pair = PAIR_W'(first_link_r + 1'b1);
    end

    fin_found    = 1'b0;
    fin_use_word = 1'b0;
    fin_link     = link_r;
    fin_addr     = '0;
    fin_drop     = 1'b0;
    fin_wr       = 1'b0;
    fin_alloc    = 1'b0;
    fin_release  = 1'b0;
    fin_used     = used_r;
    fin_pair     = pair_r;

    case (op_r)
      OP_CONNECT, OP_PAIR_DONE: begin
        fin_pair = alloc_pair;
        if (s_ok) begin
          fin_found    = 1'b1;
          fin_use_word = 1'b1;
          fin_wr       = 1'b1;
          fin_alloc    = 1'b1;
          if (!hit_vld_r) begin
            fin_used = used_r + CntW'(1);
          end
        end else begin
          fin_drop = has_addr_r;
          fin_addr = has_addr_r ? addr_r : '0;
        end
      end
      OP_DISCONNECT: begin
        fin_found   = hit_vld_r;
        fin_release = hit_vld_r;
        if (hit_vld_r) begin
          fin_used = used_r - CntW'(1);
        end
        fin_pair = other_vld_r ? PAIR_W'(other_link_r + 1'b1) : '0;
      end
      OP_BIND: begin
        if (member_bad) begin
          fin_use_word = hit_vld_r;
        end else if (s_ok) begin
          fin_found    = 1'b1;
          fin_use_word = 1'b1;
          fin_wr       = 1'b1;
          fin_alloc    = 1'b1;
          if (!hit_vld_r) begin
            fin_used = used_r + CntW'(1);
          end
        end
      end
      OP_RSSI: begin
        fin_found    = hit_vld_r && ok_r;
        fin_use_word = hit_vld_r;
        fin_wr       = hit_vld_r && ok_r;
      end
      OP_FIND_LINK: begin
        fin_found    = hit_vld_r;
        fin_use_word = hit_vld_r;
      end
      OP_FIND_MEMBER: begin
        fin_found    = hit_vld_r;
        fin_use_word = hit_vld_r;
        fin_link     = '0;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    link_nxt       = link_r;
    member_nxt     = member_r;
    rssi_nxt       = rssi_r;
    ok_nxt         = ok_r;
    addr_nxt       = addr_r;
    has_addr_nxt   = has_addr_r;
    active_nxt     = active_r;
    used_nxt       = used_r;
    pair_nxt       = pair_r;
    issue_nxt      = issue_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    list_n_nxt     = list_n_r;
    hit_vld_nxt    = hit_vld_r;
    hit_idx_nxt    = hit_idx_r;
    hit_word_nxt   = hit_word_r;
    free_vld_nxt   = free_vld_r;
    free_idx_nxt   = free_idx_r;
    first_vld_nxt  = first_vld_r;
    first_idx_nxt  = first_idx_r;
    first_link_nxt = first_link_r;
    other_vld_nxt  = other_vld_r;
    other_link_nxt = other_link_r;
    out_vld_nxt    = out_vld_r && !out_ch.ready;
    out_found_nxt  = out_found_r;
    out_link_nxt   = out_link_r;
    out_member_nxt = out_member_r;
    out_rssi_nxt   = out_rssi_r;
    out_addr_nxt   = out_addr_r;
    out_drop_nxt   = out_drop_r;
    out_pair_nxt   = out_pair_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = chk_idx_r;
    wr_data        = clr_word;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          op_nxt        = op_t'(in_ch.operation);
          link_nxt      = in_ch.link_id;
          member_nxt    = in_ch.member_in;
          rssi_nxt      = in_ch.rssi_in;
          ok_nxt        = in_ch.status_ok;
          addr_nxt      = in_ch.peer_addr;
          has_addr_nxt  = in_ch.addr_present;
          issue_nxt     = '0;
          list_n_nxt    = '0;
          hit_vld_nxt   = 1'b0;
          free_vld_nxt  = 1'b0;
          first_vld_nxt = 1'b0;
          other_vld_nxt = 1'b0;
          state_nxt     = (op_t'(in_ch.operation) == OP_LIST) ? ST_LIST_SKIP : ST_SCAN;
        end
      end
      ST_SCAN, ST_CLEAR: begin
        // read one slot a cycle, compare it the cycle after
        if (issue_r != SlotsCnt) begin
          rd_en       = 1'b1;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = walk_idx;
          issue_nxt   = issue_r + CntW'(1);
        end
        if (state_r == ST_SCAN && chk_vld_r) begin
          if (key_hit && !hit_vld_r) begin
            hit_vld_nxt  = 1'b1;
            hit_idx_nxt  = chk_idx_r;
            hit_word_nxt = rd_data;
          end
          if (!chk_act && !free_vld_r) begin
            free_vld_nxt = 1'b1;
            free_idx_nxt = chk_idx_r;
          end
          if (chk_act && !first_vld_r) begin
            first_vld_nxt  = 1'b1;
            first_idx_nxt  = chk_idx_r;
            first_link_nxt = rd_data.link;
          end
          if (chk_act && !cmp.link_hit && !other_vld_r) begin
            other_vld_nxt  = 1'b1;
            other_link_nxt = rd_data.link;
          end
        end
        // bind takes its member away from every other slot
        if (state_r == ST_CLEAR && chk_vld_r && s_ok && cmp.member_hit &&
            (chk_idx_r != s_idx)) begin
          wr_en = 1'b1;
        end
        if (chk_last) begin
          issue_nxt   = '0;
          chk_vld_nxt = 1'b0;
          if (state_r == ST_SCAN && op_r == OP_BIND && !member_bad) begin
            state_nxt = ST_CLEAR;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          wr_en   = fin_wr;
          wr_addr = s_idx;
          wr_data = new_word;
          if (fin_alloc) begin
            active_nxt[s_idx] = 1'b1;
          end
          if (fin_release) begin
            active_nxt[hit_idx_r] = 1'b0;
          end
          used_nxt       = fin_used;
          pair_nxt       = fin_pair;
          out_vld_nxt    = 1'b1;
          out_found_nxt  = fin_found;
          out_link_nxt   = fin_use_word ? new_word.link : fin_link;
          out_member_nxt = fin_use_word ? new_word.member : MEMBER_NONE;
          out_rssi_nxt   = fin_use_word ? new_word.rssi : '0;
          out_addr_nxt   = fin_use_word ? new_word.addr : fin_addr;
          out_drop_nxt   = fin_drop;
          out_pair_nxt   = fin_pair;
          out_count_nxt  = COUNT_W'(fin_used);
          out_last_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_LIST_SKIP: begin
        if (issue_r == SlotsCnt) begin
          // nothing active: a single empty result
          if (out_free) begin
            out_vld_nxt    = 1'b1;
            out_found_nxt  = 1'b0;
            out_link_nxt   = '0;
            out_member_nxt = MEMBER_NONE;
            out_rssi_nxt   = '0;
            out_addr_nxt   = '0;
            out_drop_nxt   = 1'b0;
            out_pair_nxt   = pair_r;
            out_count_nxt  = COUNT_W'(used_r);
            out_last_nxt   = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end else if (active_r[walk_idx]) begin
          rd_en     = 1'b1;
          state_nxt = ST_LIST_EMIT;
        end else begin
          issue_nxt = issue_r + CntW'(1);
        end
      end
      ST_LIST_EMIT: begin
        if (out_free) begin
          out_vld_nxt    = 1'b1;
          out_found_nxt  = 1'b1;
          out_link_nxt   = rd_data.link;
          out_member_nxt = rd_data.member;
          out_rssi_nxt   = rd_data.rssi;
          out_addr_nxt   = rd_data.addr;
          out_drop_nxt   = 1'b0;
          out_pair_nxt   = pair_r;
          out_count_nxt  = COUNT_W'(used_r);
          out_last_nxt   = list_last;
          issue_nxt      = issue_r + CntW'(1);
          list_n_nxt     = list_n_r + LIST_CNT_W'(1);
          state_nxt      = list_last ? ST_IDLE : ST_LIST_SKIP;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= '0;
      used_r      <= '0;
      pair_r      <= '0;
      issue_r     <= '0;
      chk_vld_r   <= 1'b0;
      list_n_r    <= '0;
      hit_vld_r   <= 1'b0;
      free_vld_r  <= 1'b0;
      first_vld_r <= 1'b0;
      other_vld_r <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      used_r      <= used_nxt;
      pair_r      <= pair_nxt;
      issue_r     <= issue_nxt;
      chk_vld_r   <= chk_vld_nxt;
      list_n_r    <= list_n_nxt;
      hit_vld_r   <= hit_vld_nxt;
      free_vld_r  <= free_vld_nxt;
      first_vld_r <= first_vld_nxt;
      other_vld_r <= other_vld_nxt;
      out_vld_r   <= out_vld_nxt;
    end
    op_r         <= op_nxt;
    link_r       <= link_nxt;
    member_r     <= member_nxt;
    rssi_r       <= rssi_nxt;
    ok_r         <= ok_nxt;
    addr_r       <= addr_nxt;
    has_addr_r   <= has_addr_nxt;
    chk_idx_r    <= chk_idx_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_word_r   <= hit_word_nxt;
    free_idx_r   <= free_idx_nxt;
    first_idx_r  <= first_idx_nxt;
    first_link_r <= first_link_nxt;
    other_link_r <= other_link_nxt;
    out_found_r  <= out_found_nxt;
    out_link_r   <= out_link_nxt;
    out_member_r <= out_member_nxt;
    out_rssi_r   <= out_rssi_nxt;
    out_addr_r   <= out_addr_nxt;
    out_drop_r   <= out_drop_nxt;
    out_pair_r   <= out_pair_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_vld_r;
  assign out_ch.found        = out_found_r;
  assign out_ch.link_out     = out_link_r;
  assign out_ch.member_out   = out_member_r;
  assign out_ch.rssi_out     = out_rssi_r;
  assign out_ch.addr_out     = out_addr_r;
  assign out_ch.drop_request = out_drop_r;
  assign out_ch.pair_handle  = out_pair_r;
  assign out_ch.active_count = out_count_r;
  assign out_ch.last         = out_last_r;

endmodule

// ===== hw/rtl/lmt_checks.sv =====
// port level checks of the link member table, bound to the top level
module lmt_checks import lmt_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_found,
  input logic                out_drop,
  input logic                out_last,
  input logic [LINK_W-1:0]   out_link,
  input logic [ADDR_W-1:0]   out_addr
);

  // an accepted request makes the block busy in the cycle after
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while the previous one was still starting");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_link) && $stable(out_addr) &&
                                   $stable(out_last)))
    else $error("stalled result changed");

  // only a list walk gives non-final results, and it blocks new requests
  a_list_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_found && !in_ready))
    else $error("non-final result outside a list walk");

  a_drop_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_drop) |-> (!out_found && out_last))
    else $error("drop request on a successful result");

endmodule

bind link_member_table lmt_checks u_lmt_checks (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_found (out_ch.found),
  .out_drop  (out_ch.drop_request),
  .out_last  (out_ch.last),
  .out_link  (out_ch.link_out),
  .out_addr  (out_ch.addr_out)
);

// ===== verif/link_member_table_test.sv =====
// self-checking testbench of the link member table with its own table predictor
`timescale 1ns / 100ps

module link_member_table_test;
  import lmt_pkg::*;

  localparam int unsigned TBL_SLOTS     = SLOTS_DEF;
  localparam int unsigned SETTLE_CYCLES = 2 * TBL_SLOTS + 8;
  localparam int unsigned SHOWN_MAX     = 10;
  localparam int unsigned POOL_SIZE     = 12;

  localparam op_t BUSY_OPS [8] = '{OP_CONNECT, OP_CONNECT, OP_PAIR_DONE, OP_BIND, OP_RSSI,
                                   OP_FIND_LINK, OP_FIND_MEMBER, OP_LIST};

  typedef struct packed {
    op_t                      op;
    logic [LINK_W-1:0]        link;
    logic [MEMBER_W-1:0]      member;
    logic signed [RSSI_W-1:0] rssi;
    logic                     ok;
    logic [ADDR_W-1:0]        addr;
    logic                     has_addr;
  } link_req_t;

  typedef struct packed {
    logic                     found;
    logic [LINK_W-1:0]        link;
    logic [MEMBER_W-1:0]      member;
    logic signed [RSSI_W-1:0] rssi;
    logic [ADDR_W-1:0]        addr;
    logic                     drop;
    logic [PAIR_W-1:0]        pair;
    logic [COUNT_W-1:0]       count;
    logic                     last;
  } link_res_t;

  typedef enum int unsigned {RX_OPEN, RX_LOSSY, RX_PERIODIC, RX_CHOKED} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  lmt_in_if  req_ch ();
  lmt_out_if res_ch ();

  link_member_table u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (req_ch),
    .out_ch      (res_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted table contents
  logic                     tbl_act    [TBL_SLOTS] = '{default: 1'b0};
  logic [LINK_W-1:0]        tbl_link   [TBL_SLOTS] = '{default: '0};
  logic [MEMBER_W-1:0]      tbl_member [TBL_SLOTS] = '{default: '0};
  logic signed [RSSI_W-1:0] tbl_rssi   [TBL_SLOTS] = '{default: '0};
  logic [ADDR_W-1:0]        tbl_addr   [TBL_SLOTS] = '{default: '0};
  int unsigned              used_slots    = 0;
  logic [PAIR_W-1:0]        pair_handle_q = '0;
  logic signed [RSSI_W-1:0] fresh_rssi    = RSSI_UNKNOWN_RST;

  link_req_t         link_reqs[$];
  link_res_t         link_results[$];
  logic [LINK_W-1:0] link_pool [POOL_SIZE];
  int unsigned       mismatches = 0;

  int unsigned burst_left;
  int unsigned gap_left;
  rx_mode_t    rx_mode;
  int unsigned rx_left;
  link_res_t   seen_res;

  function automatic int slot_of_link(logic [LINK_W-1:0] id);
    for (int i = 0; i < TBL_SLOTS; i++)
      if (tbl_act[i] && tbl_link[i] == id) return i;
    return -1;
  endfunction

  function automatic int slot_of_member(logic [MEMBER_W-1:0] m);
    if (m == MEMBER_NONE || m == MEMBER_BCAST) return -1;
    for (int i = 0; i < TBL_SLOTS; i++)
      if (tbl_act[i] && tbl_member[i] == m) return i;
    return -1;
  endfunction

  // reuse the slot of this link, else open the lowest free one
  function automatic int claim_slot(logic [LINK_W-1:0] id);
    int s;
    s = slot_of_link(id);
    if (s >= 0) return s;
    for (int i = 0; i < TBL_SLOTS; i++) begin
      if (!tbl_act[i]) begin
        tbl_act[i]    = 1'b1;
        tbl_link[i]   = id;
        tbl_member[i] = MEMBER_NONE;
        tbl_rssi[i]   = fresh_rssi;
        used_slots++;
        return i;
      end
    end
    return -1;
  endfunction

  function automatic void refresh_pair(logic [LINK_W-1:0] idle_val);
    if (used_slots == 0) begin
      pair_handle_q = idle_val;
      return;
    end
    for (int i = 0; i < TBL_SLOTS; i++) begin
      if (tbl_act[i]) begin
        pair_handle_q = tbl_link[i] + 1'b1;
        return;
      end
    end
  endfunction

  function automatic link_res_t slot_view(logic found, logic [LINK_W-1:0] link, int s,
                                          logic drop, logic [ADDR_W-1:0] drop_addr,
                                          logic last);
    link_res_t r;
    r.found = found;
    if (s >= 0) begin
      r.link   = tbl_link[s];
      r.member = tbl_member[s];
      r.rssi   = tbl_rssi[s];
      r.addr   = tbl_addr[s];
    end else begin
      r.link   = link;
      r.member = '0;
      r.rssi   = '0;
      r.addr   = drop ? drop_addr : '0;
    end
    r.drop  = drop;
    r.pair  = pair_handle_q;
    r.count = used_slots[COUNT_W-1:0];
    r.last  = last;
    return r;
  endfunction

  // updates the predicted table for one request and queues its results
  task automatic apply_link_op(link_req_t q);
    int s;
    int n_act;
    int n;
    logic [LINK_W-1:0] link_next;
    link_next = q.link + 1'b1;
    case (q.op)
      OP_CONNECT, OP_PAIR_DONE: begin
        s = claim_slot(q.link);
        if (s >= 0 && q.op == OP_CONNECT && q.has_addr) tbl_addr[s] = q.addr;
        refresh_pair(q.op == OP_CONNECT ? {LINK_W{1'b0}} : link_next);
        if (s < 0) link_results.push_back(slot_view(1'b0, q.link, -1, q.has_addr, q.addr, 1'b1));
        else link_results.push_back(slot_view(1'b1, q.link, s, 1'b0, '0, 1'b1));
      end
      OP_DISCONNECT: begin
        s = slot_of_link(q.link);
        if (s >= 0) begin
          tbl_act[s]    = 1'b0;
          tbl_link[s]   = '0;
          tbl_member[s] = MEMBER_NONE;
          tbl_addr[s]   = '0;
          tbl_rssi[s]   = fresh_rssi;
          if (used_slots > 0) used_slots--;
        end
        refresh_pair('0);
        link_results.push_back(slot_view(s >= 0, q.link, -1, 1'b0, '0, 1'b1));
      end
      OP_BIND: begin
        if (q.member == MEMBER_NONE || q.member > MEMBER_MAX) begin
          link_results.push_back(slot_view(1'b0, q.link, slot_of_link(q.link), 1'b0, '0, 1'b1));
        end else begin
          s = claim_slot(q.link);
          if (s < 0) begin
            link_results.push_back(slot_view(1'b0, q.link, -1, 1'b0, '0, 1'b1));
          end else begin
            // a member id belongs to one link only
            for (int i = 0; i < TBL_SLOTS; i++)
              if (tbl_act[i] && tbl_link[i] != q.link && tbl_member[i] == q.member)
                tbl_member[i] = MEMBER_NONE;
            tbl_member[s] = q.member;
            link_results.push_back(slot_view(1'b1, q.link, s, 1'b0, '0, 1'b1));
          end
        end
      end
      OP_RSSI: begin
        s = slot_of_link(q.link);
        if (s >= 0 && q.ok) tbl_rssi[s] = q.rssi;
        link_results.push_back(slot_view(s >= 0 && q.ok, q.link, s, 1'b0, '0, 1'b1));
      end
      OP_FIND_LINK: begin
        s = slot_of_link(q.link);
        link_results.push_back(slot_view(s >= 0, q.link, s, 1'b0, '0, 1'b1));
      end
      OP_FIND_MEMBER: begin
        s = slot_of_member(q.member);
        link_results.push_back(slot_view(s >= 0, '0, s, 1'b0, '0, 1'b1));
      end
      default: begin
        n_act = 0;
        for (int i = 0; i < TBL_SLOTS; i++)
          if (tbl_act[i]) n_act++;
        if (n_act > MAX_RESULTS) n_act = MAX_RESULTS;
        if (n_act == 0) begin
          link_results.push_back(slot_view(1'b0, '0, -1, 1'b0, '0, 1'b1));
        end else begin
          n = 0;
          for (int i = 0; i < TBL_SLOTS; i++) begin
            if (tbl_act[i] && n < n_act) begin
              link_results.push_back(slot_view(1'b1, '0, i, 1'b0, '0, n == n_act - 1));
              n++;
            end
          end
        end
      end
    endcase
  endtask

  function automatic string show_res(link_res_t r);
    return $sformatf("found=%0b link=%h member=%h rssi=%0d addr=%h drop=%0b pair=%h count=%0d last=%0b",
                     r.found, r.link, r.member, r.rssi, r.addr, r.drop, r.pair, r.count,
                     r.last);
  endfunction

  function automatic void report_mismatch(string msg);
    mismatches++;
    if (mismatches <= SHOWN_MAX) $display("mismatch at %0t: %s", $realtime, msg);
  endfunction

  // request driver: bursts of random length, random gaps in between
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) apply_link_op(link_reqs.pop_front());
      if (req_ch.valid && !req_ch.ready) begin
        // hold the request until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (link_reqs.size() != 0) begin
        req_ch.valid        <= 1'b1;
        req_ch.operation    <= link_reqs[0].op;
        req_ch.link_id      <= link_reqs[0].link;
        req_ch.member_in    <= link_reqs[0].member;
        req_ch.rssi_in      <= link_reqs[0].rssi;
        req_ch.status_ok    <= link_reqs[0].ok;
        req_ch.peer_addr    <= link_reqs[0].addr;
        req_ch.addr_present <= link_reqs[0].has_addr;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // result monitor and receiver stall pattern
  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      seen_res = '{found: res_ch.found, link: res_ch.link_out, member: res_ch.member_out,
                   rssi: res_ch.rssi_out, addr: res_ch.addr_out, drop: res_ch.drop_request,
                   pair: res_ch.pair_handle, count: res_ch.active_count, last: res_ch.last};
      if (link_results.size() == 0) begin
        report_mismatch({"unexpected result ", show_res(seen_res)});
      end else begin
        if (seen_res !== link_results[0])
          report_mismatch({"\n  exp ", show_res(link_results[0]), "\n  got ", show_res(seen_res)});
        void'(link_results.pop_front());
      end
    end
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 120);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN:     res_ch.ready <= 1'b1;
      RX_LOSSY:    res_ch.ready <= ($urandom_range(0, 3) != 0);
      RX_PERIODIC: res_ch.ready <= (rx_left % 7) >= 3;
      default:     res_ch.ready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  task automatic push_req(op_t op, logic [LINK_W-1:0] link,
                          logic [MEMBER_W-1:0] member = '0,
                          logic signed [RSSI_W-1:0] rssi = '0, logic ok = 1'b1,
                          logic [ADDR_W-1:0] addr = '0, logic has_addr = 1'b0);
    link_reqs.push_back('{op: op, link: link, member: member, rssi: rssi, ok: ok,
                          addr: addr, has_addr: has_addr});
  endtask

  task automatic queue_random(int unsigned n_items, int unsigned churn);
    link_req_t q;
    bit [31:0] rnd;
    for (int k = 0; k < n_items; k++) begin
      rnd = $urandom;
      if ($urandom_range(0, 99) < churn) q.op = OP_DISCONNECT;
      else q.op = BUSY_OPS[$urandom_range(0, 7)];
      // some noise: any operation on any link
      if ($urandom_range(0, 19) == 0) q.op = op_t'(rnd[2:0]);
      q.link     = ($urandom_range(0, 4) == 0) ? rnd[31:16] : link_pool[$urandom_range(0, POOL_SIZE - 1)];
      q.member   = ($urandom_range(0, 3) == 0) ? rnd[15:8] : MEMBER_W'($urandom_range(1, 5));
      q.rssi     = RSSI_W'($urandom_range(0, 255));
      q.ok       = ($urandom_range(0, 4) != 0);
      q.addr     = ADDR_W'({$urandom, $urandom});
      q.has_addr = ($urandom_range(0, 3) != 0);
      link_reqs.push_back(q);
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (link_reqs.size() != 0 || req_ch.valid || link_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_fresh_rssi(logic signed [RSSI_W-1:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_RSSI_UNKNOWN, 2'b00};
    cfg_pwdata  <= {{(CFG_DATA_W - RSSI_W){value[RSSI_W-1]}}, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk);
    while (!cfg_pready);
    fresh_rssi = value;
    // read back
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(negedge clk);
    while (!cfg_pready);
    if (cfg_prdata[RSSI_W-1:0] !== value)
      report_mismatch($sformatf("register read exp %h got %h", value, cfg_prdata));
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  initial begin
    #3_000_000;
    $display("FAIL link_member_table");
    $finish;
  end

  initial begin
    bit [31:0] rnd;
    rst_n               = 1'b0;
    cfg_psel            = 1'b0;
    cfg_penable         = 1'b0;
    cfg_pwrite          = 1'b0;
    cfg_paddr           = '0;
    cfg_pwdata          = '0;
    req_ch.valid        = 1'b0;
    req_ch.operation    = '0;
    req_ch.link_id      = '0;
    req_ch.member_in    = '0;
    req_ch.rssi_in      = '0;
    req_ch.status_ok    = 1'b0;
    req_ch.peer_addr    = '0;
    req_ch.addr_present = 1'b0;
    res_ch.ready        = 1'b0;
    rx_mode             = RX_OPEN;
    rx_left             = 0;
    link_pool[0] = 16'h0000;
    link_pool[1] = 16'hFFFF;
    link_pool[2] = 16'h0001;
    link_pool[3] = 16'h8000;
    link_pool[4] = 16'h7FFF;
    for (int i = 5; i < POOL_SIZE; i++) link_pool[i] = LINK_W'($urandom);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed requests, fresh slot strength still at its reset value
    push_req(OP_LIST, 16'h0000);
    push_req(OP_FIND_LINK, 16'hFFFF);
    push_req(OP_DISCONNECT, 16'h1234);
    // pair handle wraps, pair done keeps no address
    push_req(OP_PAIR_DONE, 16'hFFFF, '0, '0, 1'b1, 48'h1234_5678_9ABC, 1'b1);
    push_req(OP_CONNECT, 16'h0000, '0, '0, 1'b1, 48'hFFFF_FFFF_FFFF, 1'b1);
    push_req(OP_CONNECT, 16'hFFFF);
    push_req(OP_BIND, 16'h0000, MEMBER_BCAST);
    push_req(OP_BIND, 16'h0000, MEMBER_NONE);
    push_req(OP_BIND, 16'h0000, MEMBER_MAX);
    // same member moves to another link
    push_req(OP_BIND, 16'hFFFF, MEMBER_MAX);
    push_req(OP_BIND, 16'h0007, 8'd1);
    push_req(OP_RSSI, 16'h0007, '0, 8'sd127, 1'b1);
    push_req(OP_RSSI, 16'h0007, '0, -8'sd128, 1'b0);
    push_req(OP_RSSI, 16'h0099, '0, -8'sd128, 1'b1);
    push_req(OP_FIND_MEMBER, 16'h0000, MEMBER_MAX);
    push_req(OP_FIND_MEMBER, 16'h0000, MEMBER_NONE);
    push_req(OP_FIND_MEMBER, 16'h0000, MEMBER_BCAST);
    push_req(OP_CONNECT, 16'h8000, '0, '0, 1'b1, 48'h0000_0000_0000, 1'b1);
    push_req(OP_CONNECT, 16'h7FFF, '0, '0, 1'b1, ADDR_W'({$urandom, $urandom}), 1'b1);
    push_req(OP_CONNECT, 16'h0003, '0, '0, 1'b1, ADDR_W'({$urandom, $urandom}), 1'b1);
    push_req(OP_CONNECT, 16'h0004);
    push_req(OP_CONNECT, 16'h0005, '0, '0, 1'b1, 48'hA5A5_5A5A_F00F, 1'b1);
    // table full: drop request only with an address
    push_req(OP_CONNECT, 16'hABCD, '0, '0, 1'b1, 48'h0F0F_F0F0_1234, 1'b1);
    push_req(OP_PAIR_DONE, 16'hABCD);
    push_req(OP_BIND, 16'hABCD, 8'd9);
    push_req(OP_LIST, 16'h0000);
    push_req(OP_DISCONNECT, 16'hFFFF);
    push_req(OP_FIND_LINK, 16'h0000);
    wait_idle();

    write_fresh_rssi(8'sd127);
    queue_random(95, 15);
    wait_idle();
    write_fresh_rssi(-8'sd128);
    queue_random(95, 35);
    wait_idle();
    rnd = $urandom;
    write_fresh_rssi(rnd[RSSI_W-1:0]);
    queue_random(90, 10);
    wait_idle();

    if (mismatches == 0 && link_results.size() == 0) begin
      $display("PASS link_member_table");
    end else begin
      $display("FAIL link_member_table");
    end
    $finish;
  end

endmodule
